FILE: rtl/segment_intersection_test_macros.svh
// Assertion macros shared by the segment intersection test RTL.
`ifndef SEGMENT_INTERSECTION_TEST_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SIT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sit_pkg.sv
// Types and constants shared by the segment intersection test RTL.
package sit_pkg;

  localparam int NUM_POINTS = 1024;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = $clog2(NUM_POINTS);
  localparam int TOL_BITS   = 20;
  // coordinate difference, product, cross product and its magnitude
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int MAG_BITS   = CROSS_BITS - 1;

  typedef enum logic [2:0] {
    CASE_DISJOINT  = 3'd0,
    CASE_SAME_SIDE = 3'd1,
    CASE_CROSSING  = 3'd2,
    CASE_COLLINEAR = 3'd3,
    CASE_TOUCHING  = 3'd4
  } sit_case_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } sit_point_t;

  // load enables for the two stages inside an orientation unit
  typedef struct packed {
    logic s2;
    logic s3;
  } sit_orient_en_t;

  typedef struct packed {
    logic                neg;
    logic [MAG_BITS-1:0] mag;
  } sit_orient_res_t;

endpackage

FILE: rtl/sit_in_if.sv
// Input channel: one segment pair per item.
interface sit_in_if
  import sit_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic        [IDX_BITS-1:0]   seg1_start_index;
  logic        [IDX_BITS-1:0]   seg1_end_index;
  logic        [IDX_BITS-1:0]   seg2_start_index;
  logic        [IDX_BITS-1:0]   seg2_end_index;
  logic signed [COORD_BITS-1:0] seg1_start_x;
  logic signed [COORD_BITS-1:0] seg1_start_y;
  logic signed [COORD_BITS-1:0] seg1_end_x;
  logic signed [COORD_BITS-1:0] seg1_end_y;
  logic signed [COORD_BITS-1:0] seg2_start_x;
  logic signed [COORD_BITS-1:0] seg2_start_y;
  logic signed [COORD_BITS-1:0] seg2_end_x;
  logic signed [COORD_BITS-1:0] seg2_end_y;

  modport source (
    output valid, seg1_start_index, seg1_end_index, seg2_start_index, seg2_end_index,
           seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
           seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
    input  ready
  );

  modport sink (
    input  valid, seg1_start_index, seg1_end_index, seg2_start_index, seg2_end_index,
           seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
           seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
    output ready
  );
endinterface

FILE: rtl/sit_out_if.sv
// Output channel: one intersection verdict per item.
interface sit_out_if
  import sit_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       intersects;
  logic [2:0] decision_case;

  modport source (
    output valid, intersects, decision_case,
    input  ready
  );

  modport sink (
    input  valid, intersects, decision_case,
    output ready
  );
endinterface

FILE: rtl/sit_orient.sv
// Two-stage orientation unit: cross product of (b-a) and (c-a), split into sign and magnitude.
module sit_orient
  import sit_pkg::*;
(
  input  logic            clk_i,
  input  sit_orient_en_t  en_i,
  input  sit_point_t      a_i,
  input  sit_point_t      b_i,
  input  sit_point_t      c_i,
  output sit_orient_res_t res_o
);

  logic signed [DIFF_BITS-1:0]  dbx, dby, dcx, dcy;
  logic signed [PROD_BITS-1:0]  prod_l_d, prod_r_d, prod_l_q, prod_r_q;
  logic signed [CROSS_BITS-1:0] cross_val;
  logic        [CROSS_BITS-1:0] cross_abs;
  sit_orient_res_t              res_d, res_q;

  assign dbx = $signed({b_i.x[COORD_BITS-1], b_i.x}) - $signed({a_i.x[COORD_BITS-1], a_i.x});
  assign dby = $signed({b_i.y[COORD_BITS-1], b_i.y}) - $signed({a_i.y[COORD_BITS-1], a_i.y});
  assign dcx = $signed({c_i.x[COORD_BITS-1], c_i.x}) - $signed({a_i.x[COORD_BITS-1], a_i.x});
  assign dcy = $signed({c_i.y[COORD_BITS-1], c_i.y}) - $signed({a_i.y[COORD_BITS-1], a_i.y});

  assign prod_l_d = dcy * dbx;
  assign prod_r_d = dcx * dby;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
    end
  end

  assign cross_val = $signed({prod_l_q[PROD_BITS-1], prod_l_q})
                   - $signed({prod_r_q[PROD_BITS-1], prod_r_q});
  assign cross_abs = cross_val[CROSS_BITS-1] ? (CROSS_BITS'(0) - cross_val) : cross_val;
  // |cross_val| stays below 2^(PROD_BITS), so the top bit of the absolute value is always clear
  assign res_d.neg = cross_val[CROSS_BITS-1];
  assign res_d.mag = cross_abs[MAG_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: rtl/segment_intersection_test.sv
// Segment intersection test: each item carries two segments as point indices in a
// lexicographically sorted store plus their endpoint coordinates; the result says whether
// they intersect and which rule decided it (disjoint index spans, same side, proper
// crossing, collinear overlap, or touching, a hit only away from shared endpoints). The block is a
// four-stage pipeline: endpoint ordering, eight parallel 17x17 products, cross-product
// differences with magnitude, then tolerance compare and decision into the output
// register. It takes one item per clock while the output is ready; an accepted item moves
// through the stages in order into the output register, and a full pipeline holds four
// items. Stalls on the output back up stage by stage and empty stages fill, so nothing is
// lost or repeated. area_tolerance is the twice-area magnitude at or below which three
// points count as collinear; write it only while no item is in flight. It resets to zero.
`include "segment_intersection_test_macros.svh"

module segment_intersection_test
  import sit_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                area_tolerance_we_i,
  input  logic [TOL_BITS-1:0] area_tolerance_wdata_i,
  sit_in_if.sink              seg_i,
  sit_out_if.source           res_o
);

  // decision flags that travel alongside the geometry
  typedef struct packed {
    logic disjoint;
    logic b1_lt_a2;
    logic shared_end;
  } sit_flags_t;

  logic [TOL_BITS-1:0] tol_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  sit_point_t p1s, p1e, p2s, p2e;
  sit_point_t lp1, hp1, lp2, hp2;
  logic [IDX_BITS-1:0] lo1, hi1, lo2, hi2;
  logic       first_is_1;
  sit_point_t a1_d, a2_d, b1_d, b2_d;
  sit_point_t a1_q, a2_q, b1_q, b2_q;
  sit_flags_t flags_d, flags1_q, flags2_q, flags3_q;

  sit_orient_en_t  oen;
  sit_orient_res_t ores [4];
  logic [3:0] nz, neg;

  logic r1_pos, r1_neg, r2_pos, r2_neg;
  logic      hit_d, hit_q;
  sit_case_e case_d, case_q;

  // Tolerance register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (area_tolerance_we_i) begin
      tol_q <= area_tolerance_wdata_i;
    end
  end

  // Stage handshake: a stage loads when it is empty or its content moves on.
  assign rdy4 = !v4_q || res_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign seg_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= seg_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: put each segment in index order, then order the segments.
  assign p1s = '{x: seg_i.seg1_start_x, y: seg_i.seg1_start_y};
  assign p1e = '{x: seg_i.seg1_end_x,   y: seg_i.seg1_end_y};
  assign p2s = '{x: seg_i.seg2_start_x, y: seg_i.seg2_start_y};
  assign p2e = '{x: seg_i.seg2_end_x,   y: seg_i.seg2_end_y};

  // A degenerate segment (equal indices) uses its start point for both ends.
  assign lo1 = (seg_i.seg1_end_index < seg_i.seg1_start_index) ?
               seg_i.seg1_end_index : seg_i.seg1_start_index;
  assign hi1 = (seg_i.seg1_end_index < seg_i.seg1_start_index) ?
               seg_i.seg1_start_index : seg_i.seg1_end_index;
  assign lp1 = (seg_i.seg1_end_index < seg_i.seg1_start_index) ? p1e : p1s;
  assign hp1 = (seg_i.seg1_end_index > seg_i.seg1_start_index) ? p1e : p1s;

  assign lo2 = (seg_i.seg2_end_index < seg_i.seg2_start_index) ?
               seg_i.seg2_end_index : seg_i.seg2_start_index;
  assign hi2 = (seg_i.seg2_end_index < seg_i.seg2_start_index) ?
               seg_i.seg2_start_index : seg_i.seg2_end_index;
  assign lp2 = (seg_i.seg2_end_index < seg_i.seg2_start_index) ? p2e : p2s;
  assign hp2 = (seg_i.seg2_end_index > seg_i.seg2_start_index) ? p2e : p2s;

  // Identical index pairs put the second segment first.
  assign first_is_1 = (lo1 < lo2) || ((lo1 == lo2) && (hi1 < hi2));
  assign a1_d = first_is_1 ? lp1 : lp2;
  assign a2_d = first_is_1 ? hp1 : hp2;
  assign b1_d = first_is_1 ? lp2 : lp1;
  assign b2_d = first_is_1 ? hp2 : hp1;

  assign flags_d.disjoint   = (hi1 <= lo2) || (hi2 <= lo1);
  assign flags_d.b1_lt_a2   = (b1_d.x < a2_d.x) || ((b1_d.x == a2_d.x) && (b1_d.y < a2_d.y));
  assign flags_d.shared_end = (a1_d == b1_d) || (a1_d == b2_d) ||
                              (a2_d == b1_d) || (a2_d == b2_d);

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      a1_q     <= a1_d;
      a2_q     <= a2_d;
      b1_q     <= b1_d;
      b2_q     <= b2_d;
      flags1_q <= flags_d;
    end
    if (rdy2) flags2_q <= flags1_q;
    if (rdy3) flags3_q <= flags2_q;
  end

  // Stages 2 and 3: four orientation units side by side.
  assign oen.s2 = rdy2;
  assign oen.s3 = rdy3;

  // sides of the first segment's ends against the second segment's line
  sit_orient u_orient_sa1 (.clk_i, .en_i(oen), .a_i(b1_q), .b_i(b2_q), .c_i(a1_q),
                           .res_o(ores[0]));
  sit_orient u_orient_sa2 (.clk_i, .en_i(oen), .a_i(b1_q), .b_i(b2_q), .c_i(a2_q),
                           .res_o(ores[1]));
  // sides of the second segment's ends against the first segment's line
  sit_orient u_orient_sb1 (.clk_i, .en_i(oen), .a_i(a1_q), .b_i(a2_q), .c_i(b1_q),
                           .res_o(ores[2]));
  sit_orient u_orient_sb2 (.clk_i, .en_i(oen), .a_i(a1_q), .b_i(a2_q), .c_i(b2_q),
                           .res_o(ores[3]));

  // Stage 4: apply the tolerance, then decide.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      nz[k]  = ores[k].mag > MAG_BITS'(tol_q);
      neg[k] = ores[k].neg;
    end
  end

  assign r1_pos = nz[0] && nz[1] && (neg[0] == neg[1]);
  assign r1_neg = nz[0] && nz[1] && (neg[0] != neg[1]);
  assign r2_pos = nz[2] && nz[3] && (neg[2] == neg[3]);
  assign r2_neg = nz[2] && nz[3] && (neg[2] != neg[3]);

  always_comb begin
    priority if (flags3_q.disjoint) begin
      hit_d  = 1'b0;
      case_d = CASE_DISJOINT;
    end else if (r1_pos || r2_pos) begin
      hit_d  = 1'b0;
      case_d = CASE_SAME_SIDE;
    end else if (r1_neg && r2_neg) begin
      hit_d  = 1'b1;
      case_d = CASE_CROSSING;
    end else if (nz == 4'b0000) begin
      // collinear: overlap when the second segment starts before the first one ends
      hit_d  = flags3_q.b1_lt_a2;
      case_d = CASE_COLLINEAR;
    end else begin
      // touching counts only away from shared endpoints
      hit_d  = !flags3_q.shared_end;
      case_d = CASE_TOUCHING;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      hit_q  <= hit_d;
      case_q <= case_d;
    end
  end

  assign res_o.valid         = v4_q;
  assign res_o.intersects    = hit_q;
  assign res_o.decision_case = case_q;

  // Checks.
  `SIT_ASSERT_NOW(a_no_hit_when_rejected, clk_i, rst_ni,
    res_o.valid && (res_o.decision_case == CASE_DISJOINT ||
    res_o.decision_case == CASE_SAME_SIDE) , !res_o.intersects,
    "rejected pair reported as intersecting")
  `SIT_ASSERT_NEXT(a_accept_fills_stage1, clk_i, rst_ni,
    seg_i.valid && seg_i.ready, v1_q,
    "accepted item did not enter the first stage")
  `SIT_ASSERT_NEXT(a_stall_holds_stage3, clk_i, rst_ni,
    res_o.valid && !res_o.ready && v3_q, v3_q && v4_q,
    "item dropped while the output stalled")

endmodule

FILE: tb/segment_intersection_test_test.sv
// Self-checking testbench for the segment intersection test block.
module segment_intersection_test_test
  import sit_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no item accepted on either channel before the run is declared hung.
  localparam int IDLE_LIMIT = 2000;
  // Length of the one long receiver hold-off, and when it starts.
  localparam int LONG_HOLD_CYCLES = 90;
  localparam int LONG_HOLD_AFTER  = 150;
  localparam int ITEMS_PER_PHASE  = 100;

  // One segment pair as it travels on the input channel.
  typedef struct packed {
    logic [IDX_BITS-1:0] s1_idx;
    logic [IDX_BITS-1:0] e1_idx;
    logic [IDX_BITS-1:0] s2_idx;
    logic [IDX_BITS-1:0] e2_idx;
    sit_point_t          s1;
    sit_point_t          e1;
    sit_point_t          s2;
    sit_point_t          e2;
  } seg_pair_t;

  typedef struct packed {
    logic      hit;
    sit_case_e kind;
  } verdict_t;

  // How the four sorted points are split into two segments.
  typedef enum int {
    SHAPE_CROSSED,
    SHAPE_NESTED,
    SHAPE_SHARED_START,
    SHAPE_SHARED_END,
    SHAPE_APART,
    SHAPE_CHAINED
  } pair_shape_e;

  // Receiver ready patterns.
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_STARVED
  } rx_pattern_e;

  logic                clk_i;
  logic                rst_ni;
  logic                tol_we;
  logic [TOL_BITS-1:0] tol_wdata;

  sit_in_if  seg_ch ();
  sit_out_if res_ch ();

  segment_intersection_test dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .area_tolerance_we_i   (tol_we),
    .area_tolerance_wdata_i(tol_wdata),
    .seg_i                 (seg_ch),
    .res_o                 (res_ch)
  );

  seg_pair_t           pending_pairs[$];
  verdict_t            expected_verdicts[$];
  logic [TOL_BITS-1:0] tol_model;
  int                  mismatches;
  int                  accepted_pairs;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic pt_before(sit_point_t a, sit_point_t b);
    return ($signed(a.x) < $signed(b.x)) ||
           (a.x == b.x && $signed(a.y) < $signed(b.y));
  endfunction

  // Sign of the twice-area of triangle (a, b, c); magnitudes within the
  // tolerance count as collinear.
  function automatic int orient_sign(sit_point_t a, sit_point_t b, sit_point_t c,
                                     logic [TOL_BITS-1:0] tol);
    longint cr;
    longint mag;
    cr = (longint'($signed(c.y)) - longint'($signed(a.y))) *
         (longint'($signed(b.x)) - longint'($signed(a.x))) -
         (longint'($signed(c.x)) - longint'($signed(a.x))) *
         (longint'($signed(b.y)) - longint'($signed(a.y)));
    mag = (cr < 0) ? -cr : cr;
    if (mag <= longint'(tol)) return 0;
    return (cr > 0) ? 1 : -1;
  endfunction

  function automatic verdict_t predict_verdict(seg_pair_t p, logic [TOL_BITS-1:0] tol);
    logic [IDX_BITS-1:0] lo1, hi1, lo2, hi2;
    sit_point_t          lp1, hp1, lp2, hp2, a1, a2, b1, b2;
    int                  sa1, sa2, sb1, sb2;
    verdict_t            v;
    // Put each segment in index order; a zero-length index span uses the start point.
    if (p.e1_idx < p.s1_idx) begin
      lo1 = p.e1_idx; hi1 = p.s1_idx; lp1 = p.e1; hp1 = p.s1;
    end else if (p.e1_idx > p.s1_idx) begin
      lo1 = p.s1_idx; hi1 = p.e1_idx; lp1 = p.s1; hp1 = p.e1;
    end else begin
      lo1 = p.s1_idx; hi1 = p.s1_idx; lp1 = p.s1; hp1 = p.s1;
    end
    if (p.e2_idx < p.s2_idx) begin
      lo2 = p.e2_idx; hi2 = p.s2_idx; lp2 = p.e2; hp2 = p.s2;
    end else if (p.e2_idx > p.s2_idx) begin
      lo2 = p.s2_idx; hi2 = p.e2_idx; lp2 = p.s2; hp2 = p.e2;
    end else begin
      lo2 = p.s2_idx; hi2 = p.s2_idx; lp2 = p.s2; hp2 = p.s2;
    end

    v.hit  = 1'b0;
    v.kind = CASE_DISJOINT;
    if (hi1 <= lo2 || hi2 <= lo1) return v;

    // Order the segments by (low index, high index); ties go to the second one.
    if (lo1 < lo2 || (lo1 == lo2 && hi1 < hi2)) begin
      a1 = lp1; a2 = hp1; b1 = lp2; b2 = hp2;
    end else begin
      a1 = lp2; a2 = hp2; b1 = lp1; b2 = hp1;
    end

    sa1 = orient_sign(b1, b2, a1, tol);
    sa2 = orient_sign(b1, b2, a2, tol);
    v.kind = CASE_SAME_SIDE;
    if (sa1 * sa2 == 1) return v;
    sb1 = orient_sign(a1, a2, b1, tol);
    sb2 = orient_sign(a1, a2, b2, tol);
    if (sb1 * sb2 == 1) return v;

    if (sa1 * sa2 == -1 && sb1 * sb2 == -1) begin
      v.hit  = 1'b1;
      v.kind = CASE_CROSSING;
    end else if (sa1 == 0 && sa2 == 0 && sb1 == 0 && sb2 == 0) begin
      v.hit  = pt_before(b1, a2);
      v.kind = CASE_COLLINEAR;
    end else begin
      v.hit  = (a1 != b1) && (a1 != b2) && (a2 != b1) && (a2 != b2);
      v.kind = CASE_TOUCHING;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  function automatic seg_pair_t pair_of(int i1s, int i1e, int i2s, int i2e,
                                        int x1s, int y1s, int x1e, int y1e,
                                        int x2s, int y2s, int x2e, int y2e);
    seg_pair_t p;
    p.s1_idx = IDX_BITS'(i1s);
    p.e1_idx = IDX_BITS'(i1e);
    p.s2_idx = IDX_BITS'(i2s);
    p.e2_idx = IDX_BITS'(i2e);
    p.s1 = {COORD_BITS'(x1s), COORD_BITS'(y1s)};
    p.e1 = {COORD_BITS'(x1e), COORD_BITS'(y1e)};
    p.s2 = {COORD_BITS'(x2s), COORD_BITS'(y2s)};
    p.e2 = {COORD_BITS'(x2e), COORD_BITS'(y2e)};
    return p;
  endfunction

  // Mostly well-formed pairs: four points sorted in store order with rising
  // indices, split into segments by a random shape. The rest is raw noise.
  function automatic seg_pair_t random_pair();
    sit_point_t          pts[4];
    sit_point_t          t;
    logic [IDX_BITS-1:0] ids[4];
    int                  sel[4];
    int                  span;
    int                  tmp;
    logic [191:0]        raw;
    pair_shape_e         shape;
    seg_pair_t           p;
    if ($urandom_range(0, 4) == 0) begin
      for (int k = 0; k < 6; k++) raw[k*32 +: 32] = $urandom;
      p = raw[$bits(seg_pair_t)-1:0];
      return p;
    end

    // Small grids give collinear and touching cases, large ones exercise the
    // full product width.
    case ($urandom_range(0, 3))
      0:       span = 4;
      1:       span = 300;
      2:       span = 4000;
      default: span = 32768;
    endcase
    for (int k = 0; k < 4; k++) begin
      tmp = int'($urandom_range(0, 2 * span - 1)) - span;
      pts[k].x = COORD_BITS'(tmp);
      tmp = int'($urandom_range(0, 2 * span - 1)) - span;
      pts[k].y = COORD_BITS'(tmp);
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3 - i; j++)
        if (pt_before(pts[j + 1], pts[j])) begin
          t = pts[j]; pts[j] = pts[j + 1]; pts[j + 1] = t;
        end

    // Rising indices, now and then a repeated one.
    ids[0] = IDX_BITS'($urandom_range(0, 1012));
    for (int k = 1; k < 4; k++)
      ids[k] = ids[k - 1] +
               IDX_BITS'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3));

    shape = pair_shape_e'($urandom_range(0, 5));
    case (shape)
      SHAPE_CROSSED:      sel = '{0, 2, 1, 3};
      SHAPE_NESTED:       sel = '{0, 3, 1, 2};
      SHAPE_SHARED_START: sel = '{0, 2, 0, 3};
      SHAPE_SHARED_END:   sel = '{1, 3, 0, 3};
      SHAPE_APART:        sel = '{0, 1, 2, 3};
      default:            sel = '{0, 1, 1, 2};
    endcase
    if ($urandom_range(0, 1)) begin tmp = sel[0]; sel[0] = sel[1]; sel[1] = tmp; end
    if ($urandom_range(0, 1)) begin tmp = sel[2]; sel[2] = sel[3]; sel[3] = tmp; end
    if ($urandom_range(0, 1)) begin
      tmp = sel[0]; sel[0] = sel[2]; sel[2] = tmp;
      tmp = sel[1]; sel[1] = sel[3]; sel[3] = tmp;
    end

    p.s1_idx = ids[sel[0]]; p.s1 = pts[sel[0]];
    p.e1_idx = ids[sel[1]]; p.e1 = pts[sel[1]];
    p.s2_idx = ids[sel[2]]; p.s2 = pts[sel[2]];
    p.e2_idx = ids[sel[3]]; p.e2 = pts[sel[3]];
    return p;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and phase sequencing
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Wait at a falling edge, when everything is settled, until no item is
  // queued, offered or awaiting its verdict.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_pairs.size() != 0 || seg_ch.valid || expected_verdicts.size() != 0);
  endtask

  task automatic write_tolerance(logic [TOL_BITS-1:0] value);
    @(posedge clk_i);
    tol_we    <= 1'b1;
    tol_wdata <= value;
    tol_model  = value;
    @(posedge clk_i);
    tol_we    <= 1'b0;
  endtask

  task automatic queue_random(int count);
    for (int n = 0; n < count; n++) pending_pairs.push_back(random_pair());
  endtask

  initial begin
    // Hold every input at a known value from time zero.
    rst_ni           = 1'b0;
    tol_we           = 1'b0;
    tol_wdata        = '0;
    tol_model        = '0;
    mismatches       = 0;
    seg_ch.valid     = 1'b0;
    seg_ch.seg1_start_index = '0;
    seg_ch.seg1_end_index   = '0;
    seg_ch.seg2_start_index = '0;
    seg_ch.seg2_end_index   = '0;
    seg_ch.seg1_start_x = '0;
    seg_ch.seg1_start_y = '0;
    seg_ch.seg1_end_x   = '0;
    seg_ch.seg1_end_y   = '0;
    seg_ch.seg2_start_x = '0;
    seg_ch.seg2_start_y = '0;
    seg_ch.seg2_end_x   = '0;
    seg_ch.seg2_end_y   = '0;
    res_ch.ready     = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pairs at the reset tolerance of zero.
    // proper crossing
    pending_pairs.push_back(pair_of(0, 2, 1, 3,  0, 0, 4, 4,  1, 4, 5, 0));
    // both points of one segment on the same side of the other
    pending_pairs.push_back(pair_of(0, 2, 1, 3,  0, 0, 4, 0,  1, 1, 5, 3));
    // disjoint index spans
    pending_pairs.push_back(pair_of(0, 1, 2, 3,  0, 0, 1, 1,  2, 2, 3, 3));
    // index spans meeting at one index
    pending_pairs.push_back(pair_of(0, 1, 1, 2,  0, 0, 1, 1,  1, 1, 2, 0));
    // collinear and overlapping
    pending_pairs.push_back(pair_of(0, 2, 1, 3,  0, 0, 4, 0,  2, 0, 6, 0));
    // collinear, second segment starting exactly at the end of the first
    pending_pairs.push_back(pair_of(0, 2, 1, 3,  0, 0, 4, 0,  4, 0, 6, 0));
    // T-junction away from the endpoints
    pending_pairs.push_back(pair_of(0, 3, 1, 2,  0, 0, 4, 0,  2, 0, 2, 5));
    // touching at a shared endpoint
    pending_pairs.push_back(pair_of(0, 2, 0, 3,  0, 0, 2, 2,  0, 0, 3, 0));
    // equal indices within one segment: end coordinates must be ignored
    pending_pairs.push_back(pair_of(5, 5, 3, 8,  2, 1, 9, 9,  0, 0, 6, 4));
    // identical index pairs with different geometry
    pending_pairs.push_back(pair_of(2, 7, 2, 7,  0, 0, 5, 5,  0, 5, 5, 0));
    // both segments given in falling index order
    pending_pairs.push_back(pair_of(2, 0, 3, 1,  4, 4, 0, 0,  5, 0, 1, 4));
    // coordinate and index extremes, crossing diagonals
    pending_pairs.push_back(pair_of(0, 1023, 1, 1022,
                                    -32768, -32768, 32767, 32767,
                                    -32768, 32767, 32767, -32768));
    // extremes on the same side
    pending_pairs.push_back(pair_of(1023, 0, 1022, 1,
                                    32767, -32768, -32768, -32768,
                                    32767, 32767, -32768, 32767));
    // all indices at the top of the store
    pending_pairs.push_back(pair_of(1023, 1023, 1023, 1023,
                                    32767, 32767, -32768, -32768,
                                    -32768, 32767, 32767, -32768));
    // coordinates out of store order: geometry follows the coordinates
    pending_pairs.push_back(pair_of(0, 2, 1, 3,  9, 9, -9, -9,  -9, 9, 9, -9));
    // zero-length segments at the same point
    pending_pairs.push_back(pair_of(4, 4, 2, 6,  1, 1, 1, 1,  1, 1, 1, 1));
    queue_random(ITEMS_PER_PHASE);

    // Sweep the tolerance through its extremes and a few values between.
    wait_idle();
    write_tolerance({TOL_BITS{1'b1}});
    queue_random(ITEMS_PER_PHASE);
    wait_idle();
    write_tolerance(TOL_BITS'($urandom_range(1, 255)));
    queue_random(ITEMS_PER_PHASE);
    wait_idle();
    write_tolerance(TOL_BITS'($urandom_range(0, (1 << TOL_BITS) - 1)));
    queue_random(ITEMS_PER_PHASE);
    wait_idle();
    write_tolerance('0);
    queue_random(ITEMS_PER_PHASE);

    // Drain, then let the clock run on so that any stray verdict shows.
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_verdicts.size() == 0)
      $display("PASS segment_intersection_test");
    else
      $display("FAIL segment_intersection_test");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued pairs in bursts of random length with random gaps.
  // ---------------------------------------------------------------------------

  int        burst_left;
  int        gap_left;
  seg_pair_t next_pair;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_ch.valid <= 1'b0;
      burst_left    = 0;
      gap_left      = 0;
    end else if (!seg_ch.valid || seg_ch.ready) begin
      // The slot is free: the current item was taken or none is offered.
      if (gap_left > 0) begin
        gap_left--;
        seg_ch.valid <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        next_pair = pending_pairs.pop_front();
        seg_ch.seg1_start_index <= next_pair.s1_idx;
        seg_ch.seg1_end_index   <= next_pair.e1_idx;
        seg_ch.seg2_start_index <= next_pair.s2_idx;
        seg_ch.seg2_end_index   <= next_pair.e2_idx;
        seg_ch.seg1_start_x     <= next_pair.s1.x;
        seg_ch.seg1_start_y     <= next_pair.s1.y;
        seg_ch.seg1_end_x       <= next_pair.e1.x;
        seg_ch.seg1_end_y       <= next_pair.e1.y;
        seg_ch.seg2_start_x     <= next_pair.s2.x;
        seg_ch.seg2_start_y     <= next_pair.s2.y;
        seg_ch.seg2_end_x       <= next_pair.e2.x;
        seg_ch.seg2_end_y       <= next_pair.e2.y;
        seg_ch.valid            <= 1'b1;
        // At the end of a burst, plan a gap and the next burst; long bursts
        // give stretches with no idling at all.
        burst_left--;
        if (burst_left <= 0) begin
          gap_left   = $urandom_range(1, 6);
          burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
        end
      end else begin
        seg_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a pattern that changes at random, plus one long
  // hold-off while the driver keeps offering, so the pipeline fills and stalls
  // its input.
  // ---------------------------------------------------------------------------

  rx_pattern_e rx_pattern;
  int          pattern_left;
  int          hold_left;
  logic        long_hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready  <= 1'b0;
      rx_pattern     = RX_OPEN;
      pattern_left   = 0;
      hold_left      = 0;
      long_hold_done = 1'b0;
    end else begin
      if (!long_hold_done && accepted_pairs >= LONG_HOLD_AFTER) begin
        hold_left      = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (pattern_left == 0) begin
        rx_pattern   = rx_pattern_e'($urandom_range(0, 2));
        pattern_left = $urandom_range(8, 48);
      end else begin
        pattern_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (rx_pattern)
          RX_OPEN:  res_ch.ready <= 1'b1;
          RX_COIN:  res_ch.ready <= 1'($urandom_range(0, 1));
          default:  res_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict each accepted pair, check each accepted verdict in order.
  // ---------------------------------------------------------------------------

  verdict_t  got_verdict;
  verdict_t  want_verdict;
  seg_pair_t taken_pair;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accepted_pairs <= 0;
    end else begin
      if (seg_ch.valid && seg_ch.ready) begin
        taken_pair = {seg_ch.seg1_start_index, seg_ch.seg1_end_index,
                      seg_ch.seg2_start_index, seg_ch.seg2_end_index,
                      seg_ch.seg1_start_x, seg_ch.seg1_start_y,
                      seg_ch.seg1_end_x, seg_ch.seg1_end_y,
                      seg_ch.seg2_start_x, seg_ch.seg2_start_y,
                      seg_ch.seg2_end_x, seg_ch.seg2_end_y};
        expected_verdicts.push_back(predict_verdict(taken_pair, tol_model));
        accepted_pairs <= accepted_pairs + 1;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict arrived with no pair pending");
        end else begin
          want_verdict = expected_verdicts.pop_front();
          got_verdict  = {res_ch.intersects, sit_case_e'(res_ch.decision_case)};
          if (got_verdict.hit !== want_verdict.hit)
            report_mismatch($sformatf("intersects %b, expected %b",
                                      got_verdict.hit, want_verdict.hit));
          if (got_verdict.kind !== want_verdict.kind)
            report_mismatch($sformatf("decision_case %0d, expected %0d",
                                      res_ch.decision_case, want_verdict.kind));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves an item for too long.
  // ---------------------------------------------------------------------------

  int idle_cycles;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if ((seg_ch.valid && seg_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL segment_intersection_test");
        $finish;
      end
    end
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/sit_pkg.sv
rtl/sit_in_if.sv
rtl/sit_out_if.sv
rtl/sit_orient.sv
rtl/segment_intersection_test.sv
tb/segment_intersection_test_test.sv
